[rtl/core/kcl_pkg.sv]
// Shared types and constants for the keypad code lock.
`timescale 1ns / 1ps

package kcl_pkg;

  // Key request codes
  localparam logic [1:0] REQ_DIGIT = 2'd0;
  localparam logic [1:0] REQ_ENTER = 2'd1;
  localparam logic [1:0] REQ_SET   = 2'd2;

  // Event result codes
  localparam logic [2:0] EV_TAKEN   = 3'd0;
  localparam logic [2:0] EV_DROPPED = 3'd1;
  localparam logic [2:0] EV_SAVED   = 3'd2;
  localparam logic [2:0] EV_CORRECT = 3'd3;
  localparam logic [2:0] EV_WRONG   = 3'd4;
  localparam logic [2:0] EV_SETMODE = 3'd5;
  localparam logic [2:0] EV_REFUSED = 3'd6;
  localparam logic [2:0] EV_HUNG    = 3'd7;

  // Display characters and limits
  localparam logic [7:0] ECHO_STAR  = 8'h2A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [3:0] DIGIT_MAX  = 4'd9;
  localparam int         SHOWN_W    = 20;

  // Beep counts
  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_ONE   = 2'd1;
  localparam logic [1:0] BEEP_TWO   = 2'd2;

  // One key beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] digit;
  } req_t;

  // One result beat
  typedef struct packed {
    logic [2:0]         event_res;
    logic [7:0]         echo_char;
    logic [SHOWN_W-1:0] shown_code;
    logic               locked;
    logic               wrong_flag;
    logic [1:0]         beeps;
    logic [1:0]         wrong_count;
    logic               hung;
    logic               in_set_mode;
  } res_t;

endpackage

[rtl/core/kcl_req_if.sv]
// Key request channel: valid/ready handshake with decoded key payload.
`timescale 1ns / 1ps

interface kcl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] digit;

  modport source (output valid, output req_type, output digit, input ready);
  modport sink   (input valid, input req_type, input digit, output ready);
endinterface

[rtl/core/kcl_res_if.sv]
// Result channel: valid/ready handshake with lock event payload.
`timescale 1ns / 1ps

interface kcl_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  echo_char;
  logic [19:0] shown_code;
  logic        locked;
  logic        wrong_flag;
  logic [1:0]  beeps;
  logic [1:0]  wrong_count;
  logic        hung;
  logic        in_set_mode;

  modport source (output valid, output event_res, output echo_char, output shown_code,
                  output locked, output wrong_flag, output beeps, output wrong_count,
                  output hung, output in_set_mode, input ready);
  modport sink   (input valid, input event_res, input echo_char, input shown_code,
                  input locked, input wrong_flag, input beeps, input wrong_count,
                  input hung, input in_set_mode, output ready);
endinterface

[rtl/core/kcl_in_stage.sv]
// Input register stage: captures one key beat and holds it until the engine fires.
`timescale 1ns / 1ps

module kcl_in_stage (
  input  logic          clk,
  input  logic          rst,
  kcl_req_if.sink       keys,
  input  logic          advance,
  output logic          s1_valid,
  output kcl_pkg::req_t s1_req
);
  import kcl_pkg::*;

  // Free when empty or when the held beat moves on this cycle
  assign keys.ready = !s1_valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (keys.ready) begin
      s1_valid <= keys.valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (keys.valid && keys.ready) begin
      s1_req.req_type <= keys.req_type;
      s1_req.digit    <= keys.digit;
    end
  end

endmodule

[rtl/core/kcl_engine.sv]
// Lock state and single-pass evaluation of one key beat.
`timescale 1ns / 1ps

module kcl_engine #(
  parameter int CODE_DIGITS = 5,
  parameter int MAX_WRONG   = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  kcl_pkg::req_t req,
  output kcl_pkg::res_t res
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int WA_W  = $clog2(MAX_WRONG + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);
  localparam logic [WA_W-1:0]  WA_MAX   = WA_W'(MAX_WRONG);

  // State
  logic [3:0]       stored_code [CODE_DIGITS];
  logic [3:0]       entry_buffer [CODE_DIGITS];
  logic [CNT_W-1:0] entry_count;
  logic             setting_mode;
  logic             set_used;
  logic             lock_state;
  logic [WA_W-1:0]  wrong_attempts;
  logic             wrong_led;

  logic [CNT_W-1:0] entry_count_next;
  logic             setting_mode_next;
  logic             set_used_next;
  logic             lock_state_next;
  logic [WA_W-1:0]  wrong_attempts_next;
  logic             wrong_led_next;

  logic               code_we;
  logic               buf_we;
  logic [IDX_W-1:0]   wr_idx;
  logic               hung_now;
  logic               match;
  logic [SHOWN_W-1:0] packed_code;
  logic [3:0]         wa_wide;

  assign wr_idx   = entry_count[IDX_W-1:0];
  assign hung_now = (wrong_attempts >= WA_MAX);
  assign wa_wide  = 4'(wrong_attempts_next);

  // Full-length compare of entry against stored code
  always_comb begin
    match = (entry_count == CNT_FULL);
    for (int k = 0; k < CODE_DIGITS; k++) begin
      if (entry_buffer[k] != stored_code[k]) begin
        match = 1'b0;
      end
    end
  end

  // Stored code as BCD, first digit highest, low nibbles kept
  always_comb begin
    packed_code = '0;
    for (int k = 0; k < CODE_DIGITS; k++) begin
      packed_code = {packed_code[SHOWN_W-5:0], stored_code[k]};
    end
  end

  // Evaluate one key beat
  always_comb begin
    entry_count_next    = entry_count;
    setting_mode_next   = setting_mode;
    set_used_next       = set_used;
    lock_state_next     = lock_state;
    wrong_attempts_next = wrong_attempts;
    wrong_led_next      = wrong_led;
    code_we             = 1'b0;
    buf_we              = 1'b0;
    res                 = '0;
    res.event_res       = EV_DROPPED;
    res.beeps           = BEEP_NONE;

    if (hung_now) begin
      res.event_res = EV_HUNG;
    end else begin
      case (req.req_type)
        REQ_DIGIT: begin
          if (req.digit <= DIGIT_MAX && entry_count < CNT_FULL) begin
            if (setting_mode) begin
              code_we       = 1'b1;
              res.echo_char = 8'(ASCII_ZERO + {4'd0, req.digit});
            end else begin
              buf_we        = 1'b1;
              res.echo_char = ECHO_STAR;
            end
            entry_count_next = CNT_W'(entry_count + 1'b1);
            res.event_res    = EV_TAKEN;
          end
        end
        REQ_ENTER: begin
          if (setting_mode) begin
            setting_mode_next = 1'b0;
            res.shown_code    = packed_code;
            res.event_res     = EV_SAVED;
          end else if (match) begin
            lock_state_next = !lock_state;
            wrong_led_next  = 1'b0;
            res.beeps       = BEEP_ONE;
            res.event_res   = EV_CORRECT;
          end else begin
            wrong_led_next      = 1'b1;
            res.beeps           = BEEP_TWO;
            wrong_attempts_next = WA_W'(wrong_attempts + 1'b1);
            res.event_res       = (wrong_attempts_next >= WA_MAX) ? EV_HUNG : EV_WRONG;
          end
          entry_count_next = '0;
        end
        REQ_SET: begin
          if (!set_used) begin
            set_used_next     = 1'b1;
            setting_mode_next = 1'b1;
            res.event_res     = EV_SETMODE;
          end else begin
            res.event_res = EV_REFUSED;
          end
          entry_count_next = '0;
        end
        default: begin
        end
      endcase
    end

    res.locked      = lock_state_next;
    res.wrong_flag  = wrong_led_next;
    res.wrong_count = (wa_wide > 4'd3) ? 2'd3 : wa_wide[1:0];
    res.hung        = (wrong_attempts_next >= WA_MAX);
    res.in_set_mode = setting_mode_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      setting_mode   <= 1'b0;
      set_used       <= 1'b0;
      lock_state     <= 1'b0;
      wrong_attempts <= '0;
      wrong_led      <= 1'b0;
    end else if (fire) begin
      entry_count    <= entry_count_next;
      setting_mode   <= setting_mode_next;
      set_used       <= set_used_next;
      lock_state     <= lock_state_next;
      wrong_attempts <= wrong_attempts_next;
      wrong_led      <= wrong_led_next;
    end
  end

  // Stored code digits, reset to 1 2 3 ... 9 1 2 ...
  for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_code
    localparam logic [3:0] RST_DIG = 4'((g % 9) + 1);
    always_ff @(posedge clk) begin
      if (rst) begin
        stored_code[g] <= RST_DIG;
      end else if (fire && code_we && wr_idx == IDX_W'(g)) begin
        stored_code[g] <= req.digit;
      end
    end
  end

  // Entry buffer, only read once fully written
  always_ff @(posedge clk) begin
    if (fire && buf_we) begin
      entry_buffer[wr_idx] <= req.digit;
    end
  end

  // Once hung, the attempt count is frozen
  a_hung_frozen: assert property (@(posedge clk) disable iff (rst)
    (wrong_attempts >= WA_MAX) |=> $stable(wrong_attempts))
    else $error("attempt count moved while hung");

  // A correct entry toggles the lock
  a_toggle: assert property (@(posedge clk) disable iff (rst)
    (fire && res.event_res == EV_CORRECT) |=> (lock_state != $past(lock_state)))
    else $error("correct entry did not toggle lock");

  // The set key works once only
  a_set_sticky: assert property (@(posedge clk) disable iff (rst)
    set_used |=> set_used)
    else $error("set-used flag cleared");

  // Set mode needs the set key to have been used
  a_set_mode: assert property (@(posedge clk) disable iff (rst)
    setting_mode |-> set_used)
    else $error("set mode without set key");

  // Entry count stays within the code length
  a_count: assert property (@(posedge clk) disable iff (rst)
    fire |=> (entry_count <= CNT_FULL))
    else $error("entry count overran");

endmodule

[rtl/core/kcl_out_stage.sv]
// Result register stage: holds one result beat until the sink takes it.
`timescale 1ns / 1ps

module kcl_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  kcl_pkg::res_t res_next,
  kcl_res_if.source     result,
  output logic          free
);
  import kcl_pkg::*;

  res_t res_q;

  // Room for a new beat when empty or being taken now
  assign free = !result.valid || result.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (free) begin
      result.valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_next;
    end
  end

  assign result.event_res   = res_q.event_res;
  assign result.echo_char   = res_q.echo_char;
  assign result.shown_code  = res_q.shown_code;
  assign result.locked      = res_q.locked;
  assign result.wrong_flag  = res_q.wrong_flag;
  assign result.beeps       = res_q.beeps;
  assign result.wrong_count = res_q.wrong_count;
  assign result.hung        = res_q.hung;
  assign result.in_set_mode = res_q.in_set_mode;

endmodule

[rtl/core/keypad_code_lock_top.sv]
// Keypad code lock top level.
// A key beat is captured in the input register, evaluated, and then held in the result register.
// Throughput: one key beat per cycle; the evaluation is a single pass between two registers.
// Back-pressure on the result side stalls the input register, which then drops ready.
// Reset (rst, synchronous): code 1 2 3 4 5 ..., unlocked, no attempts, pipeline empty.
`timescale 1ns / 1ps

module keypad_code_lock_top #(
  parameter int CODE_DIGITS = 5,
  parameter int MAX_WRONG   = 3
) (
  input  logic       clk,
  input  logic       rst,
  kcl_req_if.sink    keys,
  kcl_res_if.source  result
);
  import kcl_pkg::*;

  logic s1_valid;
  req_t s1_req;
  res_t res_next;
  logic out_free;
  logic advance;

  // Beat moves from input register to result register
  assign advance = s1_valid && out_free;

  kcl_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .keys     (keys),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  kcl_engine #(
    .CODE_DIGITS (CODE_DIGITS),
    .MAX_WRONG   (MAX_WRONG)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (s1_req),
    .res  (res_next)
  );

  kcl_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res_next (res_next),
    .result   (result),
    .free     (out_free)
  );

endmodule
